// ===== design/gfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfq_pkg;

	localparam int ITEM_SLOTS  = 1024;
	localparam int SLOT_BITS   = $clog2(ITEM_SLOTS);
	localparam int GROUP_COUNT = 256;
	localparam int GROUP_BITS  = $clog2(GROUP_COUNT);
	localparam int TAG_BITS    = 16;

	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [SLOT_BITS:0]    slot_cnt_t;
	typedef logic [GROUP_BITS-1:0] group_t;
	typedef logic [GROUP_BITS:0]   group_cnt_t;
	typedef logic [TAG_BITS-1:0]   tag_t;
	typedef logic [1:0]            status_t;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam status_t ST_ENQUEUED = 2'd0;
	localparam status_t ST_SERVED   = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	typedef struct packed {
		status_t status;
		tag_t    tag;
		group_t  group;
	} rsp_t;

	typedef struct packed {
		tag_t   tag;
		group_t group;
	} slot_ent_t;

	typedef struct packed {
		slot_t first;
		slot_t last;
	} grp_ent_t;

	typedef struct packed {
		logic  pop;
		logic  push;
		slot_t push_slot;
	} pool_req_t;

endpackage

`default_nettype wire

// ===== design/gfq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gfq_req_if import gfq_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   operation;
	group_t group_id;
	tag_t   item_tag;

	modport source (output valid, output operation, output group_id, output item_tag,
		input ready);
	modport sink (input valid, input operation, input group_id, input item_tag,
		output ready);
endinterface

interface gfq_rsp_if import gfq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	tag_t    served_tag;
	group_t  served_group;

	modport source (output valid, output status, output served_tag, output served_group,
		input ready);
	modport sink (input valid, input status, input served_tag, input served_group,
		output ready);
endinterface

`default_nettype wire

// ===== design/gfq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/gfq_free_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfq_free_pool import gfq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pool_req_t pool_req,
	output logic           empty,
	output slot_t          pop_slot
);

	slot_cnt_t stk_cnt_q;
	slot_cnt_t fresh_cnt_q;
	logic      from_stk_s1;
	slot_t     fresh_slot_s1;
	slot_t     stk_rdata;
	slot_cnt_t stk_top;
	slot_cnt_t fresh_top;
	logic      pop_stk;

	assign empty     = (stk_cnt_q == '0) && (fresh_cnt_q == '0);
	assign stk_top   = stk_cnt_q - slot_cnt_t'(1);
	assign fresh_top = fresh_cnt_q - slot_cnt_t'(1);
	assign pop_stk   = pool_req.pop && (stk_cnt_q != '0);
	assign pop_slot  = from_stk_s1 ? stk_rdata : fresh_slot_s1;

	gfq_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(ITEM_SLOTS)
	) u_stk_ram (
		.clk  (clk),
		.we   (pool_req.push),
		.waddr(stk_cnt_q[SLOT_BITS-1:0]),
		.wdata(pool_req.push_slot),
		.re   (pop_stk),
		.raddr(stk_top[SLOT_BITS-1:0]),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_cnt_q   <= '0;
			fresh_cnt_q <= slot_cnt_t'(ITEM_SLOTS);
			from_stk_s1 <= 1'b0;
		end else begin
			if (pool_req.pop) begin
				from_stk_s1 <= pop_stk;
				if (pop_stk) begin
					stk_cnt_q <= stk_top;
				end else begin
					fresh_cnt_q <= fresh_top;
				end
			end else if (pool_req.push) begin
				stk_cnt_q <= stk_cnt_q + slot_cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pool_req.pop) begin
			fresh_slot_s1 <= fresh_top[SLOT_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== design/grouped_fifo_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Grouped FIFO (team queue).
// req channel: one request per operation. Enqueue (operation 0) stores item_tag behind
// the last waiting member of group_id, or opens the group at the tail of the group
// order. Dequeue (operation 1) serves the oldest item of the head group.
// rsp channel: exactly one response per request, in order: status 0 enqueued,
// 1 served (served_tag, served_group valid), 2 queue empty, 3 store full and dropped.
// One request is in work at a time. Enqueue reads the group entry, then writes the
// item before the response state; dequeue runs a chain of dependent memory
// reads: group order ring, group head pointer, slot entry and next link, then
// write-back. Empty and full answers go straight to the response state. The next
// request is taken in the cycle the response register loads. Item slots come from
// a stack of released slots, and never-used slots are handed out by a counter, so
// no clearing pass follows reset. Reset clears the group order, all group marks and
// the response valid flag; the queue starts empty with all 1024 slots free. When
// the receiver stalls, the response is held and the next response waits, so the
// req side stops too.

module grouped_fifo_queue_top import gfq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	gfq_req_if.sink   req,
	gfq_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ENQ_WR   = 3'd1;
	localparam logic [2:0] S_DEQ_GRP  = 3'd2;
	localparam logic [2:0] S_DEQ_SLOT = 3'd3;
	localparam logic [2:0] S_DEQ_DONE = 3'd4;
	localparam logic [2:0] S_RESP     = 3'd5;

	logic [2:0]             state_q, state_d;
	group_t                 grp_q;
	tag_t                   tag_q;
	slot_t                  first_q;
	slot_t                  last_q;
	group_t                 head_q;
	group_t                 tail_q;
	group_cnt_t             ord_cnt_q;
	logic [GROUP_COUNT-1:0] active_q;
	rsp_t                   res_q, res_d;
	rsp_t                   out_q;
	logic                   out_valid_q;

	logic      out_free;
	logic      acc;
	logic      pool_empty;
	slot_t     pool_slot;
	pool_req_t pool_req;

	logic      slot_we, slot_re;
	slot_t     slot_waddr, slot_raddr;
	slot_ent_t slot_wdata, slot_rdata;
	logic      next_we, next_re;
	slot_t     next_waddr, next_wdata, next_rdata;
	logic      grp_we, grp_re;
	group_t    grp_waddr, grp_raddr;
	grp_ent_t  grp_wdata, grp_rdata;
	logic      ring_we, ring_re;
	group_t    ring_rdata;

	assign out_free         = !out_valid_q || rsp.ready;
	assign req.ready        = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
	assign acc              = req.valid && req.ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.served_tag   = out_q.tag;
	assign rsp.served_group = out_q.group;

	gfq_free_pool u_pool (
		.clk     (clk),
		.arst_n  (arst_n),
		.pool_req(pool_req),
		.empty   (pool_empty),
		.pop_slot(pool_slot)
	);

	gfq_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(ITEM_SLOTS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	gfq_ram #(.WIDTH($bits(slot_t)), .DEPTH(ITEM_SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.re(next_re), .raddr(slot_raddr), .rdata(next_rdata)
	);

	gfq_ram #(.WIDTH($bits(grp_ent_t)), .DEPTH(GROUP_COUNT)) u_grp_ram (
		.clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
		.re(grp_re), .raddr(grp_raddr), .rdata(grp_rdata)
	);

	gfq_ram #(.WIDTH($bits(group_t)), .DEPTH(GROUP_COUNT)) u_ring_ram (
		.clk(clk), .we(ring_we), .waddr(tail_q), .wdata(grp_q),
		.re(ring_re), .raddr(head_q), .rdata(ring_rdata)
	);

	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		pool_req   = '0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_waddr = pool_slot;
		slot_raddr = grp_rdata.first;
		slot_wdata = '{tag: tag_q, group: grp_q};
		next_we    = 1'b0;
		next_re    = 1'b0;
		next_waddr = grp_rdata.last;
		next_wdata = pool_slot;
		grp_we     = 1'b0;
		grp_re     = 1'b0;
		grp_waddr  = grp_q;
		grp_raddr  = req.group_id;
		grp_wdata  = '{first: pool_slot, last: pool_slot};
		ring_we    = 1'b0;
		ring_re    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				state_d = S_IDLE;
			end
			S_ENQ_WR: begin
				slot_we = 1'b1;
				grp_we  = 1'b1;
				if (active_q[grp_q]) begin
					next_we   = 1'b1;
					grp_wdata = '{first: grp_rdata.first, last: pool_slot};
				end else begin
					ring_we = 1'b1;
				end
				res_d   = '{status: ST_ENQUEUED, tag: '0, group: '0};
				state_d = S_RESP;
			end
			S_DEQ_GRP: begin
				grp_re    = 1'b1;
				grp_raddr = ring_rdata;
				state_d   = S_DEQ_SLOT;
			end
			S_DEQ_SLOT: begin
				slot_re = 1'b1;
				next_re = 1'b1;
				state_d = S_DEQ_DONE;
			end
			S_DEQ_DONE: begin
				pool_req.push      = 1'b1;
				pool_req.push_slot = first_q;
				if (first_q != last_q) begin
					grp_we    = 1'b1;
					grp_wdata = '{first: next_rdata, last: last_q};
				end
				res_d   = '{status: ST_SERVED, tag: slot_rdata.tag, group: slot_rdata.group};
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (acc) begin
			if (req.operation == OP_ENQ) begin
				if (pool_empty) begin
					res_d   = '{status: ST_FULL, tag: '0, group: '0};
					state_d = S_RESP;
				end else begin
					pool_req.pop = 1'b1;
					grp_re       = 1'b1;
					grp_raddr    = req.group_id;
					state_d      = S_ENQ_WR;
				end
			end else begin
				if (ord_cnt_q == '0) begin
					res_d   = '{status: ST_EMPTY, tag: '0, group: '0};
					state_d = S_RESP;
				end else begin
					ring_re = 1'b1;
					state_d = S_DEQ_GRP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			ord_cnt_q   <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_ENQ_WR) && !active_q[grp_q]) begin
				active_q[grp_q] <= 1'b1;
				tail_q          <= tail_q + group_t'(1);
				ord_cnt_q       <= ord_cnt_q + group_cnt_t'(1);
			end
			if ((state_q == S_DEQ_DONE) && (first_q == last_q)) begin
				active_q[grp_q] <= 1'b0;
				head_q          <= head_q + group_t'(1);
				ord_cnt_q       <= ord_cnt_q - group_cnt_t'(1);
			end
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (acc) begin
			grp_q <= req.group_id;
			tag_q <= req.item_tag;
		end else if (state_q == S_DEQ_GRP) begin
			grp_q <= ring_rdata;
		end
		if (state_q == S_DEQ_SLOT) begin
			first_q <= grp_rdata.first;
			last_q  <= grp_rdata.last;
		end
		if ((state_q == S_RESP) && out_free) begin
			out_q <= res_q;
		end
	end

endmodule

`default_nettype wire
